// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the register ALU checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FRAM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FRAM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fram_pkg.sv =====
// ----------------------------------------------------------------------------
// fram_pkg
// Types, codes and defaults shared by the register ALU machine.
// ----------------------------------------------------------------------------
package fram_pkg;

    localparam int DEF_NUM_REGS   = 4;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int REG_SEL_W = 2;
    localparam int IMM_W     = 32;
    localparam int OUT_W     = 32;

    typedef enum logic [2:0] {
        CMD_LOAD = 3'd0,
        CMD_OUT  = 3'd1,
        CMD_MOVE = 3'd2,
        CMD_ADD  = 3'd3,
        CMD_SUB  = 3'd4,
        CMD_DIV  = 3'd5,
        CMD_MUL  = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_VALUE    = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_DIV_OVF  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        MDU_ADD,
        MDU_SUB,
        MDU_MUL,
        MDU_DIV
    } t_mdu_op;

    typedef struct packed {
        logic    start;
        t_mdu_op op;
    } t_mdu_ctl;

    typedef struct packed {
        logic [2:0]              command;
        logic [REG_SEL_W-1:0]    dest_reg;
        logic [REG_SEL_W-1:0]    src_reg;
        logic signed [IMM_W-1:0] immediate;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_value;
        t_status                 status;
    } t_out;

endpackage

// ===== hw/rtl/four_register_alu_machine.sv =====
// Load, move and unused codes finish after the register read; output and divide faults
// pass through S_FIN into the output register; add, subtract, multiply and divide run
// in the shared unit, multiply and divide one bit per cycle. One instruction is in flight
// at a time; a result held by a stalled output delays the next result-producing instruction.
// Synchronous active-low reset empties the register file and the output register.
// ----------------------------------------------------------------------------
// four_register_alu_machine
// Small register-file machine: register file with valid bits, a sequencer and
// a shared iterative arithmetic unit behind an output register.
// ----------------------------------------------------------------------------
module four_register_alu_machine #(
    parameter int NUM_REGS   = fram_pkg::DEF_NUM_REGS,
    parameter int DATA_WIDTH = fram_pkg::DEF_DATA_WIDTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  fram_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output fram_pkg::t_out o_out
);
    import fram_pkg::*;

    localparam int IW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int XW = (IW > REG_SEL_W) ? IW : REG_SEL_W;
    localparam logic [DATA_WIDTH-1:0] W_SIGN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_FIN
    } t_state;

    t_state                   r_state;
    logic [2:0]               r_cmd;
    logic [IW-1:0]            r_dst;
    logic                     r_dst_ok;
    logic signed [IMM_W-1:0]  r_imm;
    logic                     r_a_ok;
    logic                     r_b_ok;
    logic [DATA_WIDTH-1:0]    r_rd_a;
    logic [DATA_WIDTH-1:0]    r_rd_b;
    logic                     r_neg;
    logic                     r_emit;
    logic                     r_wr;
    t_out                     r_res;
    logic                     r_ov;
    t_out                     r_out;
    logic [NUM_REGS-1:0]      r_vld;
    logic [DATA_WIDTH-1:0]    r_mem [NUM_REGS];

    logic [XW-1:0]            dst_x;
    logic [XW-1:0]            src_x;
    logic                     dst_in;
    logic                     src_in;
    logic                     accept;
    logic [DATA_WIDTH-1:0]    op_a;
    logic [DATA_WIDTH-1:0]    op_b;
    logic [DATA_WIDTH-1:0]    mag_a;
    logic [DATA_WIDTH-1:0]    mag_b;
    logic                     div_zero;
    logic                     div_ovf;
    logic                     mem_we;
    logic [DATA_WIDTH-1:0]    mem_wdata;
    t_mdu_ctl                 mdu_ctl;
    logic [DATA_WIDTH-1:0]    mdu_x;
    logic [DATA_WIDTH-1:0]    mdu_y;
    logic                     mdu_done;
    logic [DATA_WIDTH-1:0]    mdu_res;
    logic                     out_free;
    logic                     out_load;

    assign dst_x  = XW'(i_in.dest_reg);
    assign src_x  = XW'(i_in.src_reg);
    assign dst_in = {1'b0, dst_x} < (XW+1)'(NUM_REGS);
    assign src_in = {1'b0, src_x} < (XW+1)'(NUM_REGS);

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_ov || !i_out_stall;
    assign out_load   = (r_state == S_FIN) && r_emit && out_free;

    // missing or never-written registers read as zero
    assign op_a     = r_a_ok ? r_rd_a : '0;
    assign op_b     = r_b_ok ? r_rd_b : '0;
    assign mag_a    = op_a[DATA_WIDTH-1] ? -op_a : op_a;
    assign mag_b    = op_b[DATA_WIDTH-1] ? -op_b : op_b;
    assign div_zero = (op_b == '0);
    assign div_ovf  = (op_a == W_SIGN) && (op_b == '1);

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = op_b;
        mdu_ctl   = '{start: 1'b0, op: MDU_ADD};
        mdu_x     = op_a;
        mdu_y     = op_b;
        if (r_state == S_READ) begin
            case (r_cmd)
                CMD_LOAD: begin
                    mem_we    = r_dst_ok;
                    mem_wdata = DATA_WIDTH'(r_imm);
                end
                CMD_MOVE: begin
                    mem_we = r_dst_ok;
                end
                CMD_ADD: begin
                    mdu_ctl = '{start: 1'b1, op: MDU_ADD};
                end
                CMD_SUB: begin
                    mdu_ctl = '{start: 1'b1, op: MDU_SUB};
                end
                CMD_MUL: begin
                    mdu_ctl = '{start: 1'b1, op: MDU_MUL};
                end
                CMD_DIV: begin
                    if (!div_zero && !div_ovf) begin
                        mdu_ctl = '{start: 1'b1, op: MDU_DIV};
                        mdu_x   = mag_a;
                        mdu_y   = mag_b;
                    end
                end
                default: ;
            endcase
        end else if (r_state == S_FIN && r_wr) begin
            mem_we    = r_dst_ok;
            mem_wdata = r_neg ? -mdu_res : mdu_res;
        end
    end

    fram_mdu #(
        .W (DATA_WIDTH)
    ) u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mdu_ctl),
        .i_op_x  (mdu_x),
        .i_op_y  (mdu_y),
        .o_done  (mdu_done),
        .o_res   (mdu_res)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_dst] <= mem_wdata;
        end
        if (accept) begin
            r_rd_a <= r_mem[dst_x[IW-1:0]];
            r_rd_b <= r_mem[src_x[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_vld   <= '0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (mem_we) begin
                r_vld[r_dst] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd    <= i_in.command;
                        r_dst    <= dst_x[IW-1:0];
                        r_dst_ok <= dst_in;
                        r_imm    <= i_in.immediate;
                        r_a_ok   <= dst_in && r_vld[dst_x[IW-1:0]];
                        r_b_ok   <= src_in && r_vld[src_x[IW-1:0]];
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    case (r_cmd)
                        CMD_OUT: begin
                            r_emit  <= 1'b1;
                            r_wr    <= 1'b0;
                            r_neg   <= 1'b0;
                            r_res   <= '{out_value: OUT_W'(op_a), status: ST_VALUE};
                            r_state <= S_FIN;
                        end
                        CMD_ADD, CMD_SUB, CMD_MUL: begin
                            r_emit  <= 1'b0;
                            r_wr    <= 1'b1;
                            r_neg   <= 1'b0;
                            r_state <= S_EXEC;
                        end
                        CMD_DIV: begin
                            r_emit <= div_zero || div_ovf;
                            r_wr   <= !(div_zero || div_ovf);
                            r_neg  <= op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
                            if (div_zero) begin
                                r_res   <= '{out_value: '0, status: ST_DIV_ZERO};
                                r_state <= S_FIN;
                            end else if (div_ovf) begin
                                r_res   <= '{out_value: '0, status: ST_DIV_OVF};
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_EXEC;
                            end
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_EXEC: begin
                    if (mdu_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_emit) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        // hold until the output register can take the beat
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                        if (r_cmd == CMD_OUT) begin
                            r_vld <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

endmodule

// ===== hw/rtl/fram_mdu.sv =====
// ----------------------------------------------------------------------------
// fram_mdu
// Shared iterative arithmetic unit: one adder serves add and subtract in one
// step, shift-add multiply and restoring unsigned divide in W steps.
// ----------------------------------------------------------------------------
module fram_mdu #(
    parameter int W = fram_pkg::DEF_DATA_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fram_pkg::t_mdu_ctl  i_ctl,
    input  logic [W-1:0]        i_op_x,
    input  logic [W-1:0]        i_op_y,
    output logic                o_done,
    output logic [W-1:0]        o_res
);
    import fram_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    t_mdu_op       r_op;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_acc;
    logic [W-1:0]  r_x;
    logic [W-1:0]  r_y;

    logic [W:0]    add_a;
    logic [W:0]    add_b;
    logic          sub;
    logic [W+1:0]  sum;
    logic [W-1:0]  n_acc;
    logic [W-1:0]  n_x;
    logic [W-1:0]  n_y;
    logic          start_acc;

    // operand select for the one adder
    always_comb begin
        add_a = {1'b0, r_acc};
        add_b = {1'b0, r_x};
        sub   = 1'b0;
        case (r_op)
            MDU_SUB: begin
                sub = 1'b1;
            end
            MDU_DIV: begin
                add_a = {r_acc, r_x[W-1]};
                add_b = {1'b0, r_y};
                sub   = 1'b1;
            end
            default: ;
        endcase
    end

    // top bit set on subtract means borrow
    assign sum = {1'b0, add_a} + ({1'b0, add_b} ^ {(W+2){sub}}) + (W+2)'(sub);

    always_comb begin
        n_acc = r_acc;
        n_x   = r_x;
        n_y   = r_y;
        case (r_op)
            MDU_ADD, MDU_SUB: begin
                n_acc = sum[W-1:0];
            end
            MDU_MUL: begin
                if (r_y[0]) begin
                    n_acc = sum[W-1:0];
                end
                n_x = r_x << 1;
                n_y = r_y >> 1;
            end
            MDU_DIV: begin
                // restore on borrow
                n_acc = sum[W+1] ? add_a[W-1:0] : sum[W-1:0];
                n_x   = {r_x[W-2:0], ~sum[W+1]};
            end
            default: ;
        endcase
    end

    assign start_acc = (i_ctl.op == MDU_ADD) || (i_ctl.op == MDU_SUB);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_op   <= i_ctl.op;
                r_cnt  <= start_acc ? CW'(1) : CW'(W);
                r_acc  <= start_acc ? i_op_x : '0;
                r_x    <= start_acc ? i_op_y : i_op_x;
                r_y    <= i_op_y;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_x   <= n_x;
                r_y   <= n_y;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = (r_op == MDU_DIV) ? r_x : r_acc;

endmodule

// ===== hw/rtl/fram_chk.sv =====
// ----------------------------------------------------------------------------
// fram_chk
// Port-level checks for the register ALU machine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fram_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input fram_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input fram_pkg::t_out o_out
);
    import fram_pkg::*;

    logic in_beat;
    logic err_beat;
    logic out_held;

    assign in_beat  = i_in_valid && !o_in_stall;
    assign err_beat = o_out_valid && (o_out.status != ST_VALUE);
    assign out_held = o_out_valid && i_out_stall;

    // one instruction at a time: busy right after a beat is taken
    `FRAM_ASSERT_NXT(a_busy, i_clk, i_rst_n, in_beat, o_in_stall, "beat not held off")

    // a new result appears only out of a busy cycle
    `FRAM_ASSERT_IMP(a_res_work, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "no work")

    // error results carry a zero value
    `FRAM_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, err_beat, o_out.out_value == '0, "error value")

    `FRAM_ASSERT_NXT(a_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(o_out), "beat moved")

endmodule

bind four_register_alu_machine fram_chk u_fram_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

// ===== tb/sv/alu_result_checker.sv =====
// ----------------------------------------------------------------------------
// alu_result_checker
// Watches both channels of the register ALU machine, keeps a shadow register
// file, predicts every result from the accepted instructions and compares
// each delivered result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module alu_result_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  fram_pkg::t_in  i_in,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  fram_pkg::t_out i_out,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_instr_count,
    output int             o_result_count,
    output int             o_fault_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import fram_pkg::*;

    localparam logic signed [31:0] MOST_NEG  = 32'sh8000_0000;
    localparam logic signed [31:0] MINUS_ONE = -32'sd1;
    localparam int                 PRINT_CAP = 50;

    logic signed [31:0] shadow_regs [4];
    t_out               pending_results [$];

    task automatic report_mismatch(input string what);
        o_fail_count++;
        // keep the log short when the block is badly broken
        if (o_fail_count <= PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    task automatic execute_instruction(input t_in beat);
        logic signed [31:0] lhs;
        logic signed [31:0] rhs;
        t_out               res;
        lhs = shadow_regs[beat.dest_reg];
        rhs = shadow_regs[beat.src_reg];
        res.out_value = '0;
        res.status    = ST_VALUE;
        o_instr_count++;
        case (beat.command)
            CMD_LOAD: shadow_regs[beat.dest_reg] = beat.immediate;
            CMD_OUT: begin
                res.out_value = lhs;
                pending_results.push_back(res);
                foreach (shadow_regs[i]) shadow_regs[i] = '0;
            end
            CMD_MOVE: shadow_regs[beat.dest_reg] = rhs;
            CMD_ADD:  shadow_regs[beat.dest_reg] = lhs + rhs;
            CMD_SUB:  shadow_regs[beat.dest_reg] = lhs - rhs;
            CMD_MUL:  shadow_regs[beat.dest_reg] = lhs * rhs;
            CMD_DIV: begin
                // faulting divides leave the destination alone
                if (rhs == '0) begin
                    res.status = ST_DIV_ZERO;
                    pending_results.push_back(res);
                    o_fault_count++;
                end else if (lhs == MOST_NEG && rhs == MINUS_ONE) begin
                    res.status = ST_DIV_OVF;
                    pending_results.push_back(res);
                    o_fault_count++;
                end else begin
                    shadow_regs[beat.dest_reg] = lhs / rhs;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        o_result_count++;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %0d status %0d",
                                      got.out_value, got.status));
        end else begin
            want = pending_results.pop_front();
            if (got.out_value !== want.out_value) begin
                report_mismatch($sformatf("out_value %0d, want %0d",
                                          got.out_value, want.out_value));
            end
            if (got.status !== want.status) begin
                report_mismatch($sformatf("status %0d, want %0d",
                                          got.status, want.status));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (shadow_regs[i]) shadow_regs[i] = '0;
            pending_results.delete();
        end else begin
            // results always trail their instruction, so check first
            if (i_out_valid && !i_out_stall) check_result(i_out);
            if (i_in_valid && !i_in_stall) execute_instruction(i_in);
        end
        o_pending = pending_results.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the four register ALU machine: a directed pass over
// wrap-around, divide faults, register clearing and the unused code, then
// weighted random instruction streams with random idling on both channels
// and one long output hold-off that backs the machine up into its input.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fram_pkg::*;

    localparam logic [2:0]         CMD_UNUSED  = 3'd7;
    localparam logic signed [31:0] MOST_NEG    = 32'sh8000_0000;
    localparam logic signed [31:0] MOST_POS    = 32'sh7FFF_FFFF;
    localparam int                 ITEM_TARGET = 1450;
    localparam int                 HOLD_AT     = 300;
    localparam int                 HOLD_CYCLES = 400;
    localparam int                 QUIET_START = 700;
    localparam int                 QUIET_END   = 1000;
    localparam int                 DRAIN_WAIT  = 50;
    localparam int                 CYCLE_LIMIT = 500000;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    t_in  in_beat;
    logic out_valid;
    logic out_stall;
    t_out out_beat;

    int fail_count;
    int pending;
    int instr_count;
    int result_count;
    int fault_count;
    int cycles;
    int sent;
    bit sender_idle_en = 1'b1;
    bit stall_en       = 1'b1;
    bit hold_req       = 1'b0;
    bit hold_done      = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    four_register_alu_machine DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat)
    );

    alu_result_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in           (in_beat),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out          (out_beat),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_instr_count  (instr_count),
        .o_result_count (result_count),
        .o_fault_count  (fault_count)
    );

    function automatic t_in make_instr(input logic [2:0] cmd, input logic [1:0] dst,
                                       input logic [1:0] src, input logic [31:0] imm);
        t_in beat;
        beat.command   = cmd;
        beat.dest_reg  = dst;
        beat.src_reg   = src;
        beat.immediate = imm;
        return beat;
    endfunction

    function automatic logic [31:0] random_operand();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom();
            4, 5:       return 32'($signed($urandom_range(32)) - 16);
            6:          return MOST_NEG;
            7:          return MOST_POS;
            8:          return 32'hFFFF_FFFF;
            default:    return 32'($urandom_range(1));
        endcase
    endfunction

    function automatic t_in random_instr();
        int unsigned pick;
        logic [2:0]  cmd;
        pick = $urandom_range(99);
        if (pick < 28)      cmd = CMD_LOAD;
        else if (pick < 40) cmd = CMD_OUT;
        else if (pick < 48) cmd = CMD_MOVE;
        else if (pick < 58) cmd = CMD_ADD;
        else if (pick < 68) cmd = CMD_SUB;
        else if (pick < 84) cmd = CMD_DIV;
        else if (pick < 97) cmd = CMD_MUL;
        else                cmd = CMD_UNUSED;
        return make_instr(cmd, 2'($urandom_range(3)), 2'($urandom_range(3)),
                          random_operand());
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat went in.
    task automatic send_beat(input t_in beat);
        while (sender_idle_en && $urandom_range(99) < 7) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        do @(posedge clk); while (in_stall);
        if (beat.command != CMD_UNUSED) sent++;
        @(negedge clk);
    endtask

    initial begin : receiver
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall <= stall_en && ($urandom_range(99) < 7);
        end
    end

    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("run stopped at cycle limit with %0d results outstanding", pending);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        logic [1:0] num_reg;
        logic [1:0] den_reg;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_beat  = '0;
        sent     = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset contents, wrap-around, both divide faults, clearing
        send_beat(make_instr(CMD_OUT,  0, 0, '0));
        send_beat(make_instr(CMD_LOAD, 0, 0, MOST_POS));
        send_beat(make_instr(CMD_LOAD, 1, 0, 32'd1));
        send_beat(make_instr(CMD_ADD,  0, 1, '0));
        send_beat(make_instr(CMD_OUT,  0, 3, 32'hFFFF_FFFF));
        send_beat(make_instr(CMD_LOAD, 0, 0, MOST_NEG));
        send_beat(make_instr(CMD_LOAD, 3, 0, 32'hFFFF_FFFF));
        send_beat(make_instr(CMD_DIV,  0, 3, '0));
        send_beat(make_instr(CMD_DIV,  0, 2, '0));
        send_beat(make_instr(CMD_SUB,  2, 0, '0));
        send_beat(make_instr(CMD_MUL,  3, 3, '0));
        send_beat(make_instr(CMD_MOVE, 1, 2, '0));
        send_beat(make_instr(CMD_MUL,  1, 1, '0));
        send_beat(make_instr(CMD_LOAD, 0, 0, 32'd7));
        send_beat(make_instr(CMD_LOAD, 3, 0, 32'hFFFF_FFFE));
        send_beat(make_instr(CMD_DIV,  0, 3, '0));
        send_beat(make_instr(CMD_UNUSED, 3, 3, $urandom()));
        send_beat(make_instr(CMD_OUT,  0, 0, '0));
        send_beat(make_instr(CMD_OUT,  3, 0, '0));
        send_beat(make_instr(CMD_LOAD, 2, 0, 32'h0001_0000));
        send_beat(make_instr(CMD_MUL,  2, 2, '0));
        send_beat(make_instr(CMD_LOAD, 1, 0, MOST_POS));
        send_beat(make_instr(CMD_MUL,  1, 1, '0));
        send_beat(make_instr(CMD_OUT,  1, 0, '0));
        send_beat(make_instr(CMD_DIV,  2, 0, '0));

        while (sent < ITEM_TARGET) begin
            {sender_idle_en, stall_en} = (sent >= QUIET_START && sent < QUIET_END)
                                         ? 2'b00 : 2'b11;
            if (!hold_done && sent >= HOLD_AT) begin
                // block the output and keep feeding results so that the input stalls
                hold_done = 1'b1;
                hold_req  = 1'b1;
                repeat (20) begin
                    send_beat(make_instr(CMD_LOAD, 2'($urandom_range(3)), 0,
                                         random_operand()));
                    send_beat(make_instr(CMD_OUT, 2'($urandom_range(3)), 0, '0));
                end
            end else if ($urandom_range(99) < 8) begin
                num_reg = 2'($urandom_range(3));
                den_reg = num_reg ^ 2'($urandom_range(1, 3));
                send_beat(make_instr(CMD_LOAD, num_reg, 0, MOST_NEG));
                send_beat(make_instr(CMD_LOAD, den_reg, 0, 32'hFFFF_FFFF));
                send_beat(make_instr(CMD_DIV, num_reg, den_reg, $urandom()));
            end else begin
                send_beat(random_instr());
            end
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        $display("Covered %0d instructions and %0d results, %0d of them divide faults,",
                 instr_count, result_count, fault_count);
        $display("with random idling, a quiet stretch and a %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
